@@ design/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// lpht_pkg
// shared types, widths and codes for the linear probe hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

  // table depth, must be a power of two (home slot and probe wrap are masks)
  localparam int unsigned SLOTS   = 4096;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned COUNT_W = $clog2(SLOTS + 1);

  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 64;

  // configuration register
  localparam int unsigned LIMIT_W     = 13;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd2867;

  // result field widths
  localparam int unsigned SLOT_OUT_W  = 12;
  localparam int unsigned COUNT_OUT_W = 13;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned REQ_W       = 2;

  // stream widths
  localparam int unsigned IN_DATA_W  = KEY_W + VAL_W;
  localparam int unsigned OUT_BITS   = VAL_W + SLOT_OUT_W + COUNT_OUT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // mix hash shift amounts
  localparam int unsigned HASH_STEPS = 7;
  localparam int unsigned HASH_SH_A  = 21;
  localparam int unsigned HASH_SH_B  = 24;
  localparam int unsigned HASH_SH_C  = 3;
  localparam int unsigned HASH_SH_D  = 8;
  localparam int unsigned HASH_SH_E  = 14;
  localparam int unsigned HASH_SH_F  = 2;
  localparam int unsigned HASH_SH_G  = 4;
  localparam int unsigned HASH_SH_H  = 28;
  localparam int unsigned HASH_SH_I  = 31;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_LOCATE = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK      = 2'd0,
    RES_MISSING = 2'd1,
    RES_FULL    = 2'd2
  } res_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USED    = 2'd1,
    SLOT_REMOVED = 2'd2
  } slot_st_t;

  // write request into the slot stores, one enable per store
  typedef struct packed {
    logic              st_en;
    logic              key_en;
    logic              val_en;
    logic [SLOT_W-1:0] addr;
    slot_st_t          st;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  val;
  } wr_req_t;

  // registered read data of one slot
  typedef struct packed {
    slot_st_t         st;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } rd_data_t;

endpackage

@@ design/linear_probe_hash_table.sv @@
// a request is hashed, its home slot is read, then slots are probed in turn until
// an empty slot, a key hit or a full wrap, and the result is registered
// a request rejected by the load limit skips the hash and probe; its result is loaded from ST_FULL
// one request at a time: the next beat is taken once the last one ends
// reset: synchronous; counts clear, load_limit returns to 2867, then a sweep over all
// SLOTS (4096) slots marks every slot empty while s_tready stays low
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// open addressing map from 64-bit keys to 64-bit values with linear probing
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             load_limit_we,
  input  logic [lpht_pkg::LIMIT_W-1:0]     load_limit_wdata,
  // request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lpht_pkg::IN_DATA_W-1:0]   s_tdata,   // key [63:0], value [127:64]
  input  logic [lpht_pkg::REQ_W-1:0]       s_tuser,   // req_type [1:0]
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lpht_pkg::OUT_DATA_W-1:0]  m_tdata,   // found_value [63:0],
                                                      // slot_index [75:64],
                                                      // entry_count [88:76]
  output logic [lpht_pkg::STATUS_W-1:0]    m_tuser    // status [1:0]
);

  localparam int unsigned SW = lpht_pkg::SLOT_W;
  localparam int unsigned CW = lpht_pkg::COUNT_W;
  localparam int unsigned PAD_W = lpht_pkg::OUT_DATA_W - lpht_pkg::OUT_BITS;

  // one-hot sequencer
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_HASH  = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_FULL  = 4'b1000
  } state_t;

  state_t state, state_next;

  // request held while it is worked on
  lpht_pkg::req_t              req;
  logic [lpht_pkg::KEY_W-1:0]  key;
  logic [lpht_pkg::VAL_W-1:0]  val;

  // table counts and configuration
  logic [CW-1:0]                live_count, live_next;
  logic [CW-1:0]                tomb_count, tomb_next;
  logic [lpht_pkg::LIMIT_W-1:0] load_limit;

  // probe walk
  logic [SW-1:0] idx, idx_next;
  logic [SW-1:0] probes;
  logic [SW-1:0] tomb_idx;
  logic          tomb_seen;

  // hash and store connections
  logic                       hash_start;
  logic                       hash_done;
  logic [lpht_pkg::KEY_W-1:0] hash_out;
  lpht_pkg::wr_req_t          wr, wr_raw;
  lpht_pkg::rd_data_t         rd;
  logic                       clearing;

  // decision signals
  logic           accept;
  logic           over_limit;
  logic           out_free;
  logic           st_empty, st_used, st_rem;
  logic           hit, last, end_probe, fin;
  logic           tomb_any;
  logic [SW-1:0]  tomb_slot, new_slot;
  logic           is_put;
  lpht_pkg::req_t in_req;
  lpht_pkg::res_t res_status;
  logic [lpht_pkg::VAL_W-1:0] res_fval;
  logic [SW-1:0]  res_slot;
  logic           out_load;

  assign s_tready = (state == ST_IDLE) && !clearing;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign in_req   = lpht_pkg::req_t'(s_tuser);

  // load check is made before any probe, for insert and locate only
  assign over_limit = ((in_req == lpht_pkg::REQ_INSERT) || (in_req == lpht_pkg::REQ_LOCATE))
                   && ((32'(live_count) + 32'(tomb_count)) > 32'(load_limit));
  assign hash_start = accept && !over_limit;

  lpht_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .din   (s_tdata[lpht_pkg::KEY_W-1:0]),
    .done  (hash_done),
    .dout  (hash_out)
  );

  // read address runs one step ahead, so rd always holds slot idx;
  // a stalled finish keeps idx and the same slot is read again
  always_comb begin
    idx_next = idx;
    if ((state == ST_HASH) && hash_done) begin
      idx_next = hash_out[SW-1:0];
    end else if ((state == ST_PROBE) && !end_probe) begin
      idx_next = idx + 1'b1;
    end
  end

  lpht_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (idx_next),
    .wr       (wr),
    .rd       (rd),
    .clearing (clearing)
  );

  // slot under test
  assign st_empty  = (rd.st == lpht_pkg::SLOT_EMPTY);
  assign st_used   = (rd.st == lpht_pkg::SLOT_USED);
  assign st_rem    = (rd.st == lpht_pkg::SLOT_REMOVED);
  assign hit       = st_used && (rd.key == key);
  assign last      = (probes == SW'(lpht_pkg::SLOTS - 1));
  assign end_probe = st_empty || hit || last;
  assign fin       = (state == ST_PROBE) && end_probe && out_free;

  // the slot under test counts as a tombstone when it ends a full wrap
  assign tomb_any  = tomb_seen || st_rem;
  assign tomb_slot = tomb_seen ? tomb_idx : idx;
  assign new_slot  = tomb_any ? tomb_slot : idx;
  assign is_put    = (req == lpht_pkg::REQ_INSERT) || (req == lpht_pkg::REQ_LOCATE);

  // outcome of a finished probe
  always_comb begin
    res_status = lpht_pkg::RES_OK;
    res_fval   = '0;
    res_slot   = '0;
    live_next  = live_count;
    tomb_next  = tomb_count;
    wr_raw     = '0;
    if (is_put) begin
      if (hit) begin
        // key present: insert updates the value, locate just reports it
        res_slot = idx;
        if (req == lpht_pkg::REQ_INSERT) begin
          wr_raw.val_en = 1'b1;
          wr_raw.addr   = idx;
          wr_raw.val    = val;
          res_fval      = val;
        end else begin
          res_fval = rd.val;
        end
      end else if (tomb_any || st_empty) begin
        // new key goes to the first tombstone, else the empty slot
        wr_raw.st_en  = 1'b1;
        wr_raw.key_en = 1'b1;
        wr_raw.val_en = 1'b1;
        wr_raw.addr   = new_slot;
        wr_raw.st     = lpht_pkg::SLOT_USED;
        wr_raw.key    = key;
        wr_raw.val    = (req == lpht_pkg::REQ_INSERT) ? val : '0;
        live_next     = live_count + 1'b1;
        if (tomb_any) begin
          tomb_next = tomb_count - 1'b1;
        end
        res_slot = new_slot;
        res_fval = (req == lpht_pkg::REQ_INSERT) ? val : '0;
      end else begin
        // whole table walked, no room
        res_status = lpht_pkg::RES_FULL;
      end
    end else begin
      if (hit) begin
        res_slot = idx;
        res_fval = rd.val;
        if (req == lpht_pkg::REQ_REMOVE) begin
          wr_raw.st_en = 1'b1;
          wr_raw.addr  = idx;
          wr_raw.st    = lpht_pkg::SLOT_REMOVED;
          live_next    = live_count - 1'b1;
          tomb_next    = tomb_count + 1'b1;
        end
      end else begin
        res_status = lpht_pkg::RES_MISSING;
      end
    end
  end

  assign wr = fin ? wr_raw : '0;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = over_limit ? ST_FULL : ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (fin) begin
          state_next = ST_IDLE;
        end
      end
      ST_FULL: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration register, written whenever the enable is high
  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= lpht_pkg::LIMIT_RESET;
    end else if (load_limit_we) begin
      load_limit <= load_limit_wdata;
    end
  end

  // counts move only when a probe finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      tomb_count <= '0;
    end else if (fin) begin
      live_count <= live_next;
      tomb_count <= tomb_next;
    end
  end

  // probe walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      probes    <= '0;
      tomb_seen <= 1'b0;
    end else if ((state == ST_HASH) && hash_done) begin
      probes    <= '0;
      tomb_seen <= 1'b0;
    end else if ((state == ST_PROBE) && !end_probe) begin
      probes <= probes + 1'b1;
      if (st_rem && !tomb_seen) begin
        tomb_seen <= 1'b1;
      end
    end
  end

  // probe walk payload
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if ((state == ST_PROBE) && !end_probe && st_rem && !tomb_seen) begin
      tomb_idx <= idx;
    end
    if (accept) begin
      req <= in_req;
      key <= s_tdata[lpht_pkg::KEY_W-1:0];
      val <= s_tdata[lpht_pkg::IN_DATA_W-1:lpht_pkg::KEY_W];
    end
  end

  // result register, parts the result side from the request side
  assign out_load = fin || ((state == ST_FULL) && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_FULL) begin
        // rejected by the load limit, nothing changed
        m_tuser <= lpht_pkg::RES_FULL;
        m_tdata <= {PAD_W'(0),
                    lpht_pkg::COUNT_OUT_W'(live_count),
                    lpht_pkg::SLOT_OUT_W'(0),
                    lpht_pkg::VAL_W'(0)};
      end else begin
        m_tuser <= res_status;
        m_tdata <= {PAD_W'(0),
                    lpht_pkg::COUNT_OUT_W'(live_next),
                    lpht_pkg::SLOT_OUT_W'(res_slot),
                    res_fval};
      end
    end
  end

`ifndef SYNTHESIS
  // used plus removed slots never exceed the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(live_count) + 32'(tomb_count)) <= 32'(lpht_pkg::SLOTS))
    else $error("live plus tombstone count exceeds table depth");

  // the stores are written only when a probe finishes with the result slot free
  a_write_at_finish: assert property (@(posedge clk) disable iff (rst)
    (wr.st_en || wr.key_en || wr.val_en) |-> ((state == ST_PROBE) && out_free))
    else $error("store write outside a finishing probe");

  // the hash finishes only while the sequencer waits for it
  a_hash_in_step: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> (state == ST_HASH))
    else $error("hash done outside hash state");

  // counts hold unless a probe finishes
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !fin |=> ($stable(live_count) && $stable(tomb_count)))
    else $error("count changed without a finished probe");
`endif

endmodule

@@ design/lpht_hash.sv @@
// ----------------------------------------------------------------------------
// lpht_hash
// iterative 64-bit integer mix hash, one shift/add or shift/xor step a cycle
// ----------------------------------------------------------------------------
module lpht_hash (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lpht_pkg::KEY_W-1:0] din,
  output logic                       done,
  output logic [lpht_pkg::KEY_W-1:0] dout
);

  localparam int unsigned STEP_W = $clog2(lpht_pkg::HASH_STEPS);

  logic [lpht_pkg::KEY_W-1:0] n;
  logic [lpht_pkg::KEY_W-1:0] n_step;
  logic [STEP_W-1:0]          step;
  logic                       busy;

  // shared step unit: two- or three-input add, or xor with arithmetic right shift
  always_comb begin
    case (step)
      STEP_W'(0): n_step = (~n) + (n << lpht_pkg::HASH_SH_A);
      STEP_W'(1): n_step = n ^ unsigned'($signed(n) >>> lpht_pkg::HASH_SH_B);
      STEP_W'(2): n_step = n + (n << lpht_pkg::HASH_SH_C) + (n << lpht_pkg::HASH_SH_D);
      STEP_W'(3): n_step = n ^ unsigned'($signed(n) >>> lpht_pkg::HASH_SH_E);
      STEP_W'(4): n_step = n + (n << lpht_pkg::HASH_SH_F) + (n << lpht_pkg::HASH_SH_G);
      STEP_W'(5): n_step = n ^ unsigned'($signed(n) >>> lpht_pkg::HASH_SH_H);
      STEP_W'(6): n_step = n + (n << lpht_pkg::HASH_SH_I);
      default:    n_step = n;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(lpht_pkg::HASH_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n <= din;
    end else if (busy) begin
      n <= n_step;
    end
  end

  assign dout = n;

endmodule

@@ design/lpht_store.sv @@
// ----------------------------------------------------------------------------
// lpht_store
// key, value and slot status memories with registered read and reset sweep
// ----------------------------------------------------------------------------
module lpht_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lpht_pkg::SLOT_W-1:0] rd_addr,
  input  lpht_pkg::wr_req_t           wr,
  output lpht_pkg::rd_data_t          rd,
  output logic                        clearing
);

  logic [lpht_pkg::KEY_W-1:0] key_mem [lpht_pkg::SLOTS];
  logic [lpht_pkg::VAL_W-1:0] val_mem [lpht_pkg::SLOTS];
  logic [1:0]                 st_mem  [lpht_pkg::SLOTS];

  logic [lpht_pkg::SLOT_W-1:0] clr_addr;
  logic [lpht_pkg::SLOT_W-1:0] st_addr;
  logic [1:0]                  st_data;
  logic                        st_we;

  // registered read data, one register per memory
  lpht_pkg::slot_st_t          rd_st;
  logic [lpht_pkg::KEY_W-1:0]  rd_key;
  logic [lpht_pkg::VAL_W-1:0]  rd_val;

  // status sweep after reset, one slot a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == lpht_pkg::SLOT_W'(lpht_pkg::SLOTS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign st_we   = clearing | wr.st_en;
  assign st_addr = clearing ? clr_addr : wr.addr;
  assign st_data = clearing ? lpht_pkg::SLOT_EMPTY : wr.st;

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_addr] <= st_data;
    end
    rd_st <= lpht_pkg::slot_st_t'(st_mem[rd_addr]);
  end

  always_ff @(posedge clk) begin
    if (wr.key_en) begin
      key_mem[wr.addr] <= wr.key;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.val_en) begin
      val_mem[wr.addr] <= wr.val;
    end
    rd_val <= val_mem[rd_addr];
  end

  assign rd = '{st: rd_st, key: rd_key, val: rd_val};

endmodule
